// ===== src/bbmp_pkg.sv =====
// ============================================================================
// bbmp_pkg
// Shared types, codes and helpers of the base-and-bound protected memory.
// ============================================================================
package bbmp_pkg;

	// storage geometry
	localparam int MEM_DEPTH = 4096;
	localparam int WORD_BITS = 32;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	// fixed field widths
	localparam int REG_W     = 12;
	localparam int DATA_W    = 32;
	localparam int OP_W      = 3;
	localparam int STS_W     = 2;
	localparam int CFG_IDX_W = 2;

	// width that holds address + base without wrap, and any valid address
	localparam int WIDEST = (WORD_BITS > REG_W) ? WORD_BITS : REG_W;
	localparam int XW     = ((WIDEST > ADDR_W) ? WIDEST : ADDR_W) + 1;

	// operation codes
	localparam logic [OP_W-1:0] OP_READ         = 3'd0;
	localparam logic [OP_W-1:0] OP_WRITE        = 3'd1;
	localparam logic [OP_W-1:0] OP_REG_READ     = 3'd2;
	localparam logic [OP_W-1:0] OP_REG_WRITE    = 3'd3;
	localparam logic [OP_W-1:0] OP_DIRECT_READ  = 3'd4;
	localparam logic [OP_W-1:0] OP_DIRECT_WRITE = 3'd5;
	localparam logic [OP_W-1:0] OP_SET_MODE     = 3'd6;

	// status codes
	localparam logic [STS_W-1:0] STS_OK      = 2'd0;
	localparam logic [STS_W-1:0] STS_INVALID = 2'd1;
	localparam logic [STS_W-1:0] STS_BOUND   = 2'd2;
	localparam logic [STS_W-1:0] STS_PRIV    = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_USER_SPACE_END = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_SLOT      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_SLOT     = 2'd3;

	// sequencer states
	localparam int SEQ_W = 3;
	localparam logic [SEQ_W-1:0] S_CLEAR  = 3'd0;
	localparam logic [SEQ_W-1:0] S_IDLE   = 3'd1;
	localparam logic [SEQ_W-1:0] S_EXEC   = 3'd2;
	localparam logic [SEQ_W-1:0] S_XLATE  = 3'd3;
	localparam logic [SEQ_W-1:0] S_CHECK  = 3'd4;
	localparam logic [SEQ_W-1:0] S_RDATA  = 3'd5;
	localparam logic [SEQ_W-1:0] S_RESULT = 3'd6;

	typedef struct packed {
		logic [REG_W-1:0] ram_size;
		logic [REG_W-1:0] user_space_end;
		logic [REG_W-1:0] base_slot;
		logic [REG_W-1:0] limit_slot;
	} cfg_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_W-1:0]    waddr;
		logic [WORD_BITS-1:0] wdata;
		logic [ADDR_W-1:0]    raddr_a;
		logic [ADDR_W-1:0]    raddr_b;
	} mem_req_t;

	// address is 1..min(ram_size, MEM_DEPTH-1)
	function automatic logic addr_valid(logic [XW-1:0] a, logic [REG_W-1:0] ram_size);
		logic [XW-1:0] top;
		top = (XW'(ram_size) > XW'(MEM_DEPTH - 1)) ? XW'(MEM_DEPTH - 1) : XW'(ram_size);
		return (a != '0) && (a <= top);
	endfunction

endpackage

// ===== src/bbmp_req_if.sv =====
// ============================================================================
// bbmp_req_if
// Request channel: one access item with valid/ready handshake.
// ============================================================================
interface bbmp_req_if;
	logic                           valid;
	logic                           ready;
	logic [bbmp_pkg::OP_W-1:0]      operation;
	logic [bbmp_pkg::REG_W-1:0]     address;
	logic [bbmp_pkg::DATA_W-1:0]    write_data;
	logic                           kernel_request;

	modport source (output valid, output operation, output address,
		output write_data, output kernel_request, input ready);
	modport sink (input valid, input operation, input address,
		input write_data, input kernel_request, output ready);
endinterface

// ===== src/bbmp_rsp_if.sv =====
// ============================================================================
// bbmp_rsp_if
// Response channel: read data, status and mode for each item.
// ============================================================================
interface bbmp_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bbmp_pkg::DATA_W-1:0]   read_data;
	logic [bbmp_pkg::STS_W-1:0]    status;
	logic                          kernel_now;

	modport source (output valid, output read_data, output status,
		output kernel_now, input ready);
	modport sink (input valid, input read_data, input status,
		input kernel_now, output ready);
endinterface

// ===== src/base_bound_memory_protection_unit.sv =====
// ============================================================================
// base_bound_memory_protection_unit
// Word memory behind kernel/user mode with base-and-bound relocation.
// ============================================================================
// Path from accept to result: EXEC, then XLATE and CHECK for a relocated access,
// then RDATA for a read that reaches the memory, then RESULT, which waits
// while the result register is blocked.
// One item in flight: request.ready rises again the cycle after the result is
// registered, so the next item is not taken before the last one's result.
// Reset: mode is kernel, registers take their defaults, and a clearing pass
// zeroes all 4096 words, one a cycle; request.ready stays low meanwhile.
// Configuration writes are taken at any time, also during the clearing pass.
module base_bound_memory_protection_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [bbmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bbmp_pkg::REG_W-1:0]     cfg_wdata,
	bbmp_req_if.sink                       request,
	bbmp_rsp_if.source                     response
);

	bbmp_pkg::cfg_t                 cfg;
	bbmp_pkg::mem_req_t             mem_req;
	logic [bbmp_pkg::WORD_BITS-1:0] rdata_a;
	logic [bbmp_pkg::WORD_BITS-1:0] rdata_b;

	// ram_size, user window end and the two slot numbers
	bbmp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// Sequencer: decodes the item, checks mode and range, and for a relocated
	// user access first fetches base and limit words together on the two read
	// ports, then adds, checks, and only then touches the target word.
	bbmp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.request  (request),
		.response (response),
		.mem_req  (mem_req),
		.rdata_a  (rdata_a),
		.rdata_b  (rdata_b)
	);

	// Storage: one item at a time, so a write always lands before the next read.
	bbmp_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

endmodule

// ===== src/bbmp_cfg.sv =====
// ============================================================================
// bbmp_cfg
// Configuration register file, write-only.
// ============================================================================
module bbmp_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [bbmp_pkg::CFG_IDX_W-1:0] index,
	input  logic [bbmp_pkg::REG_W-1:0]     wdata,
	output bbmp_pkg::cfg_t                 cfg
);

	bbmp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ram_size       <= 12'd4095;
			cfg_q.user_space_end <= 12'd16;
			cfg_q.base_slot      <= 12'd17;
			cfg_q.limit_slot     <= 12'd18;
		end else if (wr_en) begin
			case (index)
				bbmp_pkg::CFG_RAM_SIZE:       cfg_q.ram_size       <= wdata;
				bbmp_pkg::CFG_USER_SPACE_END: cfg_q.user_space_end <= wdata;
				bbmp_pkg::CFG_BASE_SLOT:      cfg_q.base_slot      <= wdata;
				bbmp_pkg::CFG_LIMIT_SLOT:     cfg_q.limit_slot     <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/bbmp_mem.sv =====
// ============================================================================
// bbmp_mem
// Word store: one write port, two registered read ports.
// ============================================================================
module bbmp_mem (
	input  logic                              clk,
	input  bbmp_pkg::mem_req_t                req,
	output logic [bbmp_pkg::WORD_BITS-1:0]    rdata_a,
	output logic [bbmp_pkg::WORD_BITS-1:0]    rdata_b
);

	logic [bbmp_pkg::WORD_BITS-1:0] mem [bbmp_pkg::MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_a <= mem[req.raddr_a];
		rdata_b <= mem[req.raddr_b];
	end

endmodule

// ===== src/bbmp_seq.sv =====
// ============================================================================
// bbmp_seq
// Access sequencer: clearing pass, mode checks, relocation, result register.
// ============================================================================
module bbmp_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bbmp_pkg::cfg_t                    cfg,
	bbmp_req_if.sink                          request,
	bbmp_rsp_if.source                        response,
	output bbmp_pkg::mem_req_t                mem_req,
	input  logic [bbmp_pkg::WORD_BITS-1:0]    rdata_a,
	input  logic [bbmp_pkg::WORD_BITS-1:0]    rdata_b
);

	logic [bbmp_pkg::SEQ_W-1:0]     state_q;
	logic [bbmp_pkg::ADDR_W-1:0]    clr_q;
	logic                           kernel_q;
	logic                           out_valid_q;

	// held item
	logic [bbmp_pkg::OP_W-1:0]      op_q;
	logic [bbmp_pkg::REG_W-1:0]     addr_q;
	logic [bbmp_pkg::WORD_BITS-1:0] wd_q;
	logic                           kreq_q;

	// relocation
	logic [bbmp_pkg::XW-1:0]        t_q;
	logic [bbmp_pkg::WORD_BITS-1:0] limit_q;

	// pending and presented result
	logic [bbmp_pkg::DATA_W-1:0]    res_rd_q;
	logic [bbmp_pkg::STS_W-1:0]     res_sts_q;
	logic [bbmp_pkg::DATA_W-1:0]    out_rd_q;
	logic [bbmp_pkg::STS_W-1:0]     out_sts_q;
	logic                           out_kn_q;

	logic                           ex_access;
	logic                           ex_reloc;
	logic [bbmp_pkg::STS_W-1:0]     ex_sts;
	logic [bbmp_pkg::ADDR_W-1:0]    ex_idx;
	logic                           in_window;
	logic                           a_valid;
	logic                           is_write;
	logic                           is_read;
	logic [bbmp_pkg::STS_W-1:0]     chk_sts;
	logic                           chk_ok;
	logic                           out_free;

	assign is_write = (op_q == bbmp_pkg::OP_WRITE) || (op_q == bbmp_pkg::OP_REG_WRITE) ||
		(op_q == bbmp_pkg::OP_DIRECT_WRITE);
	assign is_read  = (op_q == bbmp_pkg::OP_READ) || (op_q == bbmp_pkg::OP_REG_READ) ||
		(op_q == bbmp_pkg::OP_DIRECT_READ);
	assign out_free = !out_valid_q || response.ready;

	// decode of the held item
	always_comb begin
		ex_access = 1'b0;
		ex_reloc  = 1'b0;
		ex_sts    = bbmp_pkg::STS_OK;
		ex_idx    = bbmp_pkg::ADDR_W'(addr_q);
		in_window = (addr_q != '0) && (addr_q <= cfg.user_space_end);
		a_valid   = bbmp_pkg::addr_valid(bbmp_pkg::XW'(addr_q), cfg.ram_size);
		case (op_q)
			bbmp_pkg::OP_READ, bbmp_pkg::OP_WRITE: begin
				if (kernel_q) begin
					if (a_valid) ex_access = 1'b1;
					else ex_sts = bbmp_pkg::STS_INVALID;
				end else if (in_window) begin
					ex_access = 1'b1;
				end else begin
					ex_reloc = 1'b1;
				end
			end
			bbmp_pkg::OP_REG_READ, bbmp_pkg::OP_REG_WRITE: begin
				if (!kernel_q && (addr_q > cfg.user_space_end)) ex_sts = bbmp_pkg::STS_PRIV;
				else if (!a_valid) ex_sts = bbmp_pkg::STS_INVALID;
				else ex_access = 1'b1;
			end
			bbmp_pkg::OP_DIRECT_READ, bbmp_pkg::OP_DIRECT_WRITE: begin
				if (!a_valid) ex_sts = bbmp_pkg::STS_INVALID;
				else ex_access = 1'b1;
			end
			default: ;
		endcase
	end

	// bound then range check of the translated address
	always_comb begin
		if (t_q > bbmp_pkg::XW'(limit_q)) chk_sts = bbmp_pkg::STS_BOUND;
		else if (!bbmp_pkg::addr_valid(t_q, cfg.ram_size)) chk_sts = bbmp_pkg::STS_INVALID;
		else chk_sts = bbmp_pkg::STS_OK;
		chk_ok = (chk_sts == bbmp_pkg::STS_OK);
	end

	// memory port
	always_comb begin
		mem_req.we      = 1'b0;
		mem_req.waddr   = ex_idx;
		mem_req.wdata   = wd_q;
		mem_req.raddr_a = ex_idx;
		mem_req.raddr_b = bbmp_pkg::ADDR_W'(cfg.limit_slot);
		case (state_q)
			bbmp_pkg::S_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_q;
				mem_req.wdata = '0;
			end
			bbmp_pkg::S_EXEC: begin
				mem_req.we = ex_access && is_write;
				if (ex_reloc) mem_req.raddr_a = bbmp_pkg::ADDR_W'(cfg.base_slot);
			end
			bbmp_pkg::S_CHECK: begin
				mem_req.we      = chk_ok && is_write;
				mem_req.waddr   = bbmp_pkg::ADDR_W'(t_q);
				mem_req.raddr_a = bbmp_pkg::ADDR_W'(t_q);
			end
			default: ;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bbmp_pkg::S_CLEAR;
			clr_q       <= '0;
			kernel_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// a new result takes the register as the old one leaves
			if ((state_q == bbmp_pkg::S_RESULT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				bbmp_pkg::S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == bbmp_pkg::ADDR_W'(bbmp_pkg::MEM_DEPTH - 1)) begin
						state_q <= bbmp_pkg::S_IDLE;
					end
				end
				bbmp_pkg::S_IDLE: begin
					if (request.valid) state_q <= bbmp_pkg::S_EXEC;
				end
				bbmp_pkg::S_EXEC: begin
					if (op_q == bbmp_pkg::OP_SET_MODE) kernel_q <= kreq_q;
					if (ex_reloc) state_q <= bbmp_pkg::S_XLATE;
					else if (ex_access && is_read) state_q <= bbmp_pkg::S_RDATA;
					else state_q <= bbmp_pkg::S_RESULT;
				end
				bbmp_pkg::S_XLATE: begin
					state_q <= bbmp_pkg::S_CHECK;
				end
				bbmp_pkg::S_CHECK: begin
					if (chk_ok && is_read) state_q <= bbmp_pkg::S_RDATA;
					else state_q <= bbmp_pkg::S_RESULT;
				end
				bbmp_pkg::S_RDATA: begin
					state_q <= bbmp_pkg::S_RESULT;
				end
				bbmp_pkg::S_RESULT: begin
					if (out_free) begin
						state_q <= bbmp_pkg::S_IDLE;
					end
				end
				default: state_q <= bbmp_pkg::S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			bbmp_pkg::S_IDLE: begin
				if (request.valid) begin
					op_q   <= request.operation;
					addr_q <= request.address;
					wd_q   <= bbmp_pkg::WORD_BITS'(request.write_data);
					kreq_q <= request.kernel_request;
				end
			end
			bbmp_pkg::S_EXEC: begin
				res_rd_q  <= '0;
				res_sts_q <= ex_sts;
			end
			bbmp_pkg::S_XLATE: begin
				t_q     <= bbmp_pkg::XW'(addr_q) + bbmp_pkg::XW'(rdata_a);
				limit_q <= rdata_b;
			end
			bbmp_pkg::S_CHECK: begin
				res_rd_q  <= '0;
				res_sts_q <= chk_sts;
			end
			bbmp_pkg::S_RDATA: begin
				res_rd_q <= bbmp_pkg::DATA_W'(rdata_a);
			end
			bbmp_pkg::S_RESULT: begin
				if (out_free) begin
					out_rd_q  <= res_rd_q;
					out_sts_q <= res_sts_q;
					out_kn_q  <= kernel_q;
				end
			end
			default: ;
		endcase
	end

	assign request.ready       = (state_q == bbmp_pkg::S_IDLE);
	assign response.valid      = out_valid_q;
	assign response.read_data  = out_rd_q;
	assign response.status     = out_sts_q;
	assign response.kernel_now = out_kn_q;

endmodule

// ===== dv/base_bound_memory_protection_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base_bound_memory_protection_unit_test
// Self-checking bench for the base-and-bound protected word memory: a directed
// table first, then random access streams under several register settings,
// each result checked against a hand-typed row or a model of memory, mode and relocation.
// ----------------------------------------------------------------------------
module base_bound_memory_protection_unit_test;
	import bbmp_pkg::*;

	// spare operation code, decoded as a no-op
	localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

	// long receiver hold-off, started once after this many results
	localparam int HOLD_AT     = 150;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [REG_W-1:0]  address;
		logic [DATA_W-1:0] write_data;
		logic              kernel_request;
	} access_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [STS_W-1:0]  status;
		logic              kernel_now;
	} result_t;

	// one row of the directed table; fixed marks a hand-typed result
	typedef struct packed {
		access_t acc;
		logic    fixed;
		result_t res;
	} row_t;

	localparam int NUM_ROWS = 28;

	// Starts from the reset settings: ram_size 4095, user end 16, base slot 17,
	// limit slot 18, kernel mode, memory cleared.
	localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
		// kernel: address zero is never valid, top word is
		'{'{OP_READ,         12'd0,    32'h0,         1'b0}, 1'b1, '{32'h0, STS_INVALID, 1'b1}},
		'{'{OP_DIRECT_READ,  12'd4095, 32'h0,         1'b0}, 1'b1, '{32'h0, STS_OK,      1'b1}},
		'{'{OP_WRITE,        12'd4095, 32'hFFFF_FFFF, 1'b0}, 1'b1, '{32'h0, STS_OK,      1'b1}},
		'{'{OP_READ,         12'd4095, 32'h0,         1'b0}, 1'b1, '{32'hFFFF_FFFF, STS_OK, 1'b1}},
		// base word 100, limit word 200
		'{'{OP_REG_WRITE,    12'd17,   32'd100,       1'b0}, 1'b1, '{32'h0, STS_OK,      1'b1}},
		'{'{OP_REG_WRITE,    12'd18,   32'd200,       1'b0}, 1'b1, '{32'h0, STS_OK,      1'b1}},
		'{'{OP_DIRECT_WRITE, 12'd5,    32'hA5A5_A5A5, 1'b0}, 1'b1, '{32'h0, STS_OK,      1'b1}},
		'{'{OP_WRITE,        12'd116,  32'h1234_5678, 1'b0}, 1'b1, '{32'h0, STS_OK,      1'b1}},
		// drop to user mode
		'{'{OP_SET_MODE,     12'd0,    32'h0,         1'b0}, 1'b1, '{32'h0, STS_OK,      1'b0}},
		'{'{OP_READ,         12'd5,    32'h0,         1'b1}, 1'b0, '0},
		'{'{OP_READ,         12'd16,   32'h0,         1'b0}, 1'b1, '{32'h0, STS_OK,      1'b0}},
		// user address zero is relocated too
		'{'{OP_READ,         12'd0,    32'h0,         1'b0}, 1'b0, '0},
		'{'{OP_WRITE,        12'd20,   32'hDEAD_BEEF, 1'b0}, 1'b1, '{32'h0, STS_OK,      1'b0}},
		'{'{OP_DIRECT_READ,  12'd120,  32'h0,         1'b0}, 1'b0, '0},
		// one past the limit, then exactly on it
		'{'{OP_READ,         12'd101,  32'h0,         1'b0}, 1'b1, '{32'h0, STS_BOUND,   1'b0}},
		'{'{OP_READ,         12'd100,  32'h0,         1'b0}, 1'b0, '0},
		'{'{OP_REG_READ,     12'd17,   32'h0,         1'b0}, 1'b1, '{32'h0, STS_PRIV,    1'b0}},
		'{'{OP_REG_WRITE,    12'd16,   32'd7,         1'b0}, 1'b1, '{32'h0, STS_OK,      1'b0}},
		'{'{OP_REG_READ,     12'd0,    32'h0,         1'b0}, 1'b1, '{32'h0, STS_INVALID, 1'b0}},
		'{'{OP_DIRECT_WRITE, 12'd0,    32'h1,         1'b0}, 1'b1, '{32'h0, STS_INVALID, 1'b0}},
		'{'{OP_SPARE,        12'd4095, 32'hFFFF_FFFF, 1'b1}, 1'b1, '{32'h0, STS_OK,      1'b0}},
		'{'{OP_SET_MODE,     12'd0,    32'h0,         1'b1}, 1'b1, '{32'h0, STS_OK,      1'b1}},
		'{'{OP_REG_READ,     12'd17,   32'h0,         1'b0}, 1'b0, '0},
		// limit wide open: translation passes the bound but leaves the memory
		'{'{OP_REG_WRITE,    12'd18,   32'hFFFF_FFFF, 1'b0}, 1'b1, '{32'h0, STS_OK,      1'b1}},
		'{'{OP_SET_MODE,     12'd0,    32'h0,         1'b0}, 1'b1, '{32'h0, STS_OK,      1'b0}},
		'{'{OP_READ,         12'd4000, 32'h0,         1'b0}, 1'b1, '{32'h0, STS_INVALID, 1'b0}},
		'{'{OP_READ,         12'd3995, 32'h0,         1'b0}, 1'b0, '0},
		'{'{OP_SET_MODE,     12'd0,    32'h0,         1'b1}, 1'b1, '{32'h0, STS_OK,      1'b1}}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_wdata;

	bbmp_req_if request_ch ();
	bbmp_rsp_if result_ch ();

	base_bound_memory_protection_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.request   (request_ch),
		.response  (result_ch)
	);

	// bench-side copy of the protected memory and its settings
	logic [DATA_W-1:0] mem_model [MEM_DEPTH];
	logic              model_kernel;
	cfg_t              model_cfg;

	result_t pending_results [$];
	int      mismatch_count;
	int      results_seen;
	int      src_idle_pct;
	int      sink_idle_pct;

	// 1 .. ram_size; ram_size is 12 bits so never above the top word
	function automatic logic in_ram(logic [32:0] a);
		return (a != '0) && (a <= 33'(model_cfg.ram_size));
	endfunction

	// Work out the result of one access and apply its side effects to the model.
	function automatic result_t protect_access(access_t a);
		result_t       r;
		logic [32:0]   moved;
		logic          hit;
		logic [REG_W-1:0] idx;
		r     = '0;
		hit   = 1'b0;
		idx   = a.address;
		case (a.operation)
			OP_READ, OP_WRITE: begin
				if (model_kernel) begin
					hit = in_ram(33'(a.address));
				end else if (a.address != '0 && a.address <= model_cfg.user_space_end) begin
					// user window: straight through, no ram_size check
					hit = 1'b1;
				end else begin
					moved = 33'(a.address) + 33'(mem_model[model_cfg.base_slot]);
					idx   = moved[REG_W-1:0];
					if (moved > 33'(mem_model[model_cfg.limit_slot]))
						r.status = STS_BOUND;
					else
						hit = in_ram(moved);
				end
				if (r.status == STS_OK && !hit)
					r.status = STS_INVALID;
				if (hit) begin
					if (a.operation == OP_READ)
						r.read_data = mem_model[idx];
					else
						mem_model[idx] = a.write_data;
				end
			end
			OP_REG_READ, OP_REG_WRITE: begin
				if (!model_kernel && a.address > model_cfg.user_space_end)
					r.status = STS_PRIV;
				else if (!in_ram(33'(a.address)))
					r.status = STS_INVALID;
				else if (a.operation == OP_REG_READ)
					r.read_data = mem_model[a.address];
				else
					mem_model[a.address] = a.write_data;
			end
			OP_DIRECT_READ, OP_DIRECT_WRITE: begin
				if (!in_ram(33'(a.address)))
					r.status = STS_INVALID;
				else if (a.operation == OP_DIRECT_READ)
					r.read_data = mem_model[a.address];
				else
					mem_model[a.address] = a.write_data;
			end
			OP_SET_MODE: begin
				model_kernel = a.kernel_request;
			end
			default: begin
			end
		endcase
		r.kernel_now = model_kernel;
		return r;
	endfunction

	// Offer one item, wait for it to be taken, then log its expected result.
	// Leaves valid high so a following item can go out without a gap.
	task automatic send_item(input access_t a, input logic fixed, input result_t given);
		result_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			request_ch.valid <= 1'b0;
			@(posedge clk);
		end
		request_ch.valid          <= 1'b1;
		request_ch.operation      <= a.operation;
		request_ch.address        <= a.address;
		request_ch.write_data     <= a.write_data;
		request_ch.kernel_request <= a.kernel_request;
		@(posedge clk);
		while (!request_ch.ready)
			@(posedge clk);
		predicted = protect_access(a);
		pending_results.push_back(fixed ? given : predicted);
	endtask

	// Register writes only once the block has drained.
	task automatic configure(input logic [REG_W-1:0] ram, input logic [REG_W-1:0] use_end,
			input logic [REG_W-1:0] base, input logic [REG_W-1:0] limit);
		request_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_RAM_SIZE;
		cfg_wdata <= ram;
		@(posedge clk);
		cfg_index <= CFG_USER_SPACE_END;
		cfg_wdata <= use_end;
		@(posedge clk);
		cfg_index <= CFG_BASE_SLOT;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_index <= CFG_LIMIT_SLOT;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_cfg = '{ram, use_end, base, limit};
	endtask

	// pick an address a couple of words either side of a boundary
	function automatic logic [REG_W-1:0] near(int v);
		int lo;
		int hi;
		lo = (v > 2) ? v - 2 : 0;
		hi = (v < MEM_DEPTH - 3) ? v + 2 : MEM_DEPTH - 1;
		return REG_W'($urandom_range(hi, lo));
	endfunction

	// Random accesses. In kernel mode the base and limit words are often
	// rewritten with sane values so that user accesses mostly relocate into
	// the memory; the rest of the traffic hits the boundaries or is noise.
	task automatic run_random(input int count);
		access_t          a;
		int               pick;
		logic [DATA_W-1:0] base_word;
		for (int n = 0; n < count; n++) begin
			pick             = $urandom_range(99);
			a.address        = REG_W'($urandom_range(MEM_DEPTH - 1));
			a.write_data     = $urandom;
			a.kernel_request = 1'($urandom_range(1));
			if (pick < 8) begin
				a.operation      = OP_SET_MODE;
				a.kernel_request = ($urandom_range(99) < 45);
			end else if (pick < 10) begin
				a.operation = OP_SPARE;
			end else if (pick < 24 && model_kernel) begin
				case ($urandom_range(2))
					0: a.operation = OP_WRITE;
					1: a.operation = OP_REG_WRITE;
					default: a.operation = OP_DIRECT_WRITE;
				endcase
				pick = $urandom_range(99);
				if ($urandom_range(1)) begin
					a.address = model_cfg.base_slot;
					if (pick < 70)
						a.write_data = $urandom_range(64);
					else if (pick < 85)
						a.write_data = $urandom_range(MEM_DEPTH - 1);
				end else begin
					a.address = model_cfg.limit_slot;
					base_word = mem_model[model_cfg.base_slot];
					if (pick < 70)
						a.write_data = base_word + $urandom_range(200);
					else if (pick < 85)
						a.write_data = $urandom_range(MEM_DEPTH - 1);
				end
			end else begin
				case ($urandom_range(7))
					0, 1: a.operation = OP_READ;
					2, 3: a.operation = OP_WRITE;
					4: a.operation = OP_REG_READ;
					5: a.operation = OP_REG_WRITE;
					6: a.operation = OP_DIRECT_READ;
					default: a.operation = OP_DIRECT_WRITE;
				endcase
				case ($urandom_range(3))
					0: a.address = REG_W'($urandom_range(48));
					1: a.address = near(int'(model_cfg.ram_size));
					2: a.address = near(int'(model_cfg.user_space_end));
					default: begin
					end
				endcase
				case ($urandom_range(9))
					0: a.write_data = '0;
					1: a.write_data = '1;
					default: begin
					end
				endcase
			end
			send_item(a, 1'b0, '0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side: check each item taken against the oldest expectation, then
	// choose ready for the next edge. One long hold-off lets the block back up.
	initial begin
		int      hold_left;
		result_t want;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				if (pending_results.size() == 0) begin
					$error("result item with no access outstanding");
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (result_ch.read_data !== want.read_data) begin
						$error("read_data: expected %h, got %h",
							want.read_data, result_ch.read_data);
						mismatch_count++;
					end
					if (result_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result_ch.status);
						mismatch_count++;
					end
					if (result_ch.kernel_now !== want.kernel_now) begin
						$error("kernel_now: expected %0d, got %0d",
							want.kernel_now, result_ch.kernel_now);
						mismatch_count++;
					end
				end
				results_seen++;
				if (results_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		access_t a;
		result_t given;
		arst_n                    = 1'b0;
		cfg_wr_en                <= 1'b0;
		cfg_index                <= CFG_RAM_SIZE;
		cfg_wdata                <= '0;
		request_ch.valid         <= 1'b0;
		request_ch.operation     <= OP_READ;
		request_ch.address       <= '0;
		request_ch.write_data    <= '0;
		request_ch.kernel_request <= 1'b0;
		mismatch_count            = 0;
		results_seen              = 0;
		for (int i = 0; i < MEM_DEPTH; i++)
			mem_model[i] = '0;
		model_kernel = 1'b1;
		model_cfg    = '{12'd4095, 12'd16, 12'd17, 12'd18};

		// sender sparse, receiver very sparse
		src_idle_pct  = 36;
		sink_idle_pct = 76;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed table on reset settings; first item waits out the clearing pass
		for (int i = 0; i < NUM_ROWS; i++) begin
			a     = DIRECTED_ROWS[i].acc;
			given = DIRECTED_ROWS[i].res;
			send_item(a, DIRECTED_ROWS[i].fixed, given);
		end

		// defaults written back explicitly, ram_size at the top of its range
		configure(12'd4095, 12'd16, 12'd17, 12'd18);
		run_random(105);

		// small memory, no user window: every user read or write relocates
		configure(12'd63, 12'd0, 12'd1, 12'd2);
		run_random(105);

		// roles swapped: sender idles most
		src_idle_pct  = 76;
		sink_idle_pct = 36;

		// one-word memory, whole slot range user-visible, base and limit share a slot
		configure(12'd1, 12'd4095, 12'd4095, 12'd4095);
		run_random(105);

		configure(REG_W'($urandom_range(4095, 16)), REG_W'($urandom_range(64)),
			REG_W'($urandom_range(80, 1)), REG_W'($urandom_range(80, 1)));
		run_random(105);

		// back to back on both sides
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		configure(12'd4095, 12'd0, 12'd4095, 12'd1);
		run_random(105);

		request_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
src/bbmp_pkg.sv
src/bbmp_req_if.sv
src/bbmp_rsp_if.sv
src/bbmp_cfg.sv
src/bbmp_mem.sv
src/bbmp_seq.sv
src/base_bound_memory_protection_unit.sv
dv/base_bound_memory_protection_unit_test.sv
